// ===== sv/tsd_pkg.sv =====
package tsd_pkg;

    // Sizing
    localparam int WINDOW_MAX = 16;
    localparam int COORD_BITS = 12;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 2);
    localparam int WIN_W      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W      = $clog2(WINDOW_MAX * ((1 << COORD_BITS) - 1) + 1);
    localparam int WS_W       = 5;
    localparam int STOP_W     = 12;
    localparam int TTL_W      = 15;
    localparam int CTR_W      = 16;
    localparam int THR_W      = STOP_W + WIN_W;
    localparam int ADDR_W     = 4;

    // Register reset values
    localparam int WINDOW_RESET = 10;
    localparam int STOP_RESET   = 2;
    localparam int TTL_RESET    = 10;

    // Register indexes
    localparam logic [ADDR_W-3:0] REG_WINDOW = 2'd0;
    localparam logic [ADDR_W-3:0] REG_STOP   = 2'd1;
    localparam logic [ADDR_W-3:0] REG_TTL    = 2'd2;

    typedef enum logic [1:0] {
        FUNC_POINT  = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_RELOAD = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        func_t                 func;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } item_t;

    typedef struct packed {
        logic                    moving;
        logic                    stopped;
        logic signed [CTR_W-1:0] ttl_now;
        logic                    history_ready;
    } result_t;

    typedef struct packed {
        logic [WS_W-1:0]   window_steps;
        logic [STOP_W-1:0] stop_distance;
        logic [TTL_W-1:0]  ttl_start;
    } cfg_t;

    // Work carried from the front stage to evaluation
    typedef struct packed {
        func_t            func;
        logic             eval;
        logic             base0;
        logic             hist;
        logic [SUM_W-1:0] total;
    } stage_t;

    // Clamp the window length to 1..WINDOW_MAX
    function automatic logic [WIN_W-1:0] eff_window(input logic [WS_W-1:0] ws);
        int v;
        v = int'(ws);
        if (v == 0)
        begin
            v = 1;
        end
        else if (v > WINDOW_MAX)
        begin
            v = WINDOW_MAX;
        end
        return WIN_W'(v);
    endfunction

endpackage

// ===== sv/tsd_ram.sv =====
module tsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

// ===== sv/tsd_regs.sv =====
module tsd_regs import tsd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [WS_W-1:0]   window_reg;
    logic [STOP_W-1:0] stop_reg;
    logic [TTL_W-1:0]  ttl_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WS_W'(WINDOW_RESET);
            stop_reg   <= STOP_W'(STOP_RESET);
            ttl_reg    <= TTL_W'(TTL_RESET);
        end
        else if (wr_en)
        begin
            unique case (paddr[ADDR_W-1:2])
                REG_WINDOW: window_reg <= pwdata[WS_W-1:0];
                REG_STOP:   stop_reg   <= pwdata[STOP_W-1:0];
                REG_TTL:    ttl_reg    <= pwdata[TTL_W-1:0];
                default:    ;
            endcase
        end
    end

    // Return register contents
    always_comb
    begin
        unique case (paddr[ADDR_W-1:2])
            REG_WINDOW: prdata = {{(32-WS_W){1'b0}}, window_reg};
            REG_STOP:   prdata = {{(32-STOP_W){1'b0}}, stop_reg};
            REG_TTL:    prdata = {{(32-TTL_W){1'b0}}, ttl_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.window_steps  = window_reg;
    assign cfg.stop_distance = stop_reg;
    assign cfg.ttl_start     = ttl_reg;

endmodule

// ===== sv/tsd_front.sv =====
module tsd_front import tsd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  item_t            item,
    input  logic             accept,
    output stage_t           stage,
    output logic [SUM_W-1:0] base_sum
);

    logic [COORD_BITS-1:0] last_x_reg, last_y_reg;
    logic [SUM_W-1:0]      total_reg, total_next;
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]      seen_reg, seen_next;
    logic [CNT_W-1:0]      wcnt_reg, wcnt_next;
    stage_t                stage_reg, stage_next;

    logic [WIN_W-1:0]      w_eff;
    logic [COORD_BITS-1:0] dx, dy, step_len;
    logic                  is_point, has_prev, write_dist;
    logic [PTR_W-1:0]      rd_addr;
    int                    rd_idx;

    assign w_eff    = eff_window(cfg.window_steps);
    assign is_point = accept && (item.func == FUNC_POINT);
    assign has_prev = (seen_reg != '0);
    assign write_dist = is_point && has_prev;

    // Chebyshev step from the previous point
    assign dx   = (item.pos_x > last_x_reg) ? item.pos_x - last_x_reg : last_x_reg - item.pos_x;
    assign dy   = (item.pos_y > last_y_reg) ? item.pos_y - last_y_reg : last_y_reg - item.pos_y;
    assign step_len = (dx > dy) ? dx : dy;

    // Advance running total, ring pointer and counts
    always_comb
    begin
        total_next  = total_reg;
        wr_ptr_next = wr_ptr_reg;
        seen_next   = seen_reg;
        wcnt_next   = wcnt_reg;
        if (write_dist)
        begin
            total_next  = total_reg + SUM_W'(step_len);
            wr_ptr_next = (wr_ptr_reg == PTR_W'(WINDOW_MAX - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            if (wcnt_reg < CNT_W'(WINDOW_MAX + 1))
            begin
                wcnt_next = wcnt_reg + CNT_W'(1);
            end
        end
        if (is_point && (seen_reg < CNT_W'(WINDOW_MAX + 1)))
        begin
            seen_next = seen_reg + CNT_W'(1);
        end
    end

    // Slot holding the running total from w_eff steps back
    assign rd_idx  = (int'(wr_ptr_reg) >= int'(w_eff)) ? int'(wr_ptr_reg) - int'(w_eff)
                                                      : int'(wr_ptr_reg) + WINDOW_MAX - int'(w_eff);
    assign rd_addr = PTR_W'(rd_idx);

    // Build the transaction for evaluation
    always_comb
    begin
        stage_next.func  = item.func;
        stage_next.hist  = (int'(seen_next) >= int'(w_eff) + 1);
        stage_next.eval  = is_point && stage_next.hist;
        stage_next.base0 = (int'(wcnt_next) == int'(w_eff));
        stage_next.total = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= '0;
            last_y_reg <= '0;
            total_reg  <= '0;
            wr_ptr_reg <= '0;
            seen_reg   <= '0;
            wcnt_reg   <= '0;
        end
        else
        begin
            if (is_point)
            begin
                last_x_reg <= item.pos_x;
                last_y_reg <= item.pos_y;
            end
            total_reg  <= total_next;
            wr_ptr_reg <= wr_ptr_next;
            seen_reg   <= seen_next;
            wcnt_reg   <= wcnt_next;
        end
    end

    // Hold the stage payload until the next transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

    // Ring of running totals, one per step
    tsd_ram #(
        .WIDTH(SUM_W),
        .DEPTH(WINDOW_MAX)
    ) u_ring (
        .clk  (clk),
        .we   (write_dist),
        .waddr(wr_ptr_reg),
        .wdata(total_next),
        .re   (accept),
        .raddr(rd_addr),
        .rdata(base_sum)
    );

endmodule

// ===== sv/tsd_eval.sv =====
module tsd_eval import tsd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             accept,
    input  stage_t           stage,
    input  logic [SUM_W-1:0] base_sum,
    output logic             item_ready,
    output result_t          result,
    output logic             result_valid,
    input  logic             result_ready
);

    logic                    s_valid_reg;
    logic                    out_valid_reg;
    result_t                 out_reg, out_next;
    logic [THR_W-1:0]        thr_reg;
    logic signed [CTR_W-1:0] ctr_reg, ctr_next;
    logic                    stopped_reg, stopped_next;
    logic [SUM_W-1:0]        win_sum;
    logic                    still;
    logic                    advance;

    assign advance    = s_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !s_valid_reg || advance;

    // Window sum from two running totals; truncated mean below limit is sum below limit*w
    assign win_sum = stage.base0 ? stage.total : stage.total - base_sum;
    assign still   = (int'(win_sum) < int'(thr_reg));

    // Update the stop counter and flag
    always_comb
    begin
        ctr_next     = ctr_reg;
        stopped_next = stopped_reg;
        out_next.moving = 1'b1;
        unique case (stage.func)
            FUNC_POINT:
            begin
                if (stage.eval)
                begin
                    if (still)
                    begin
                        if (ctr_reg != {1'b1, {(CTR_W-1){1'b0}}})
                        begin
                            ctr_next = ctr_reg - CTR_W'(1);
                        end
                        if (ctr_next <= 0)
                        begin
                            stopped_next    = 1'b1;
                            out_next.moving = 1'b0;
                        end
                    end
                    else if (ctr_reg != {1'b0, {(CTR_W-1){1'b1}}})
                    begin
                        ctr_next = ctr_reg + CTR_W'(1);
                    end
                end
            end
            FUNC_CLEAR:  stopped_next = 1'b0;
            FUNC_RELOAD: ctr_next = signed'({1'b0, cfg.ttl_start});
            FUNC_NONE:   ;
        endcase
        out_next.stopped       = stopped_next;
        out_next.ttl_now       = ctr_next;
        out_next.history_ready = stage.hist;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ctr_reg       <= CTR_W'(TTL_RESET);
            stopped_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ctr_reg       <= ctr_next;
                stopped_reg   <= stopped_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result and track the threshold
    always_ff @(posedge clk)
    begin
        thr_reg <= THR_W'(cfg.stop_distance) * THR_W'(eff_window(cfg.window_steps));
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

// ===== sv/track_stop_detector.sv =====
// Track stop detector.
// Item channel (item_valid/item_ready, item): one transaction per frame,
// carrying a tracked point (func point) or a command (clear the stopped
// flag, reload the stop counter). Result channel (result_valid/result_ready,
// result): exactly one result per item, in order.
// Configuration by an APB-style port: window length at 0x0, stop distance
// at 0x4, counter start at 0x8; write only while the block is idle.
// Timing: the ring read and stage load happen at the accepting edge; evaluation
// follows once the result register is free, and result_valid then rises.
// Throughput: one item per cycle while the receiver takes results, with one
// read of the ring of running totals and one stop counter update per item.
// Reset: configuration returns to its defaults, the stop counter loads the
// default start value, counts and totals clear; the ring needs no clearing.
// Receiver stall: the result is held, the staged item waits behind it and
// item_ready falls once both are occupied; nothing is dropped.
module track_stop_detector import tsd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t             cfg;
    stage_t           stage;
    logic [SUM_W-1:0] base_sum;
    logic             accept;

    assign accept = item_valid && item_ready;

    tsd_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    tsd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item),
        .accept  (accept),
        .stage   (stage),
        .base_sum(base_sum)
    );

    tsd_eval u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .stage       (stage),
        .base_sum    (base_sum),
        .item_ready  (item_ready),
        .result      (result),
        .result_valid(result_valid),
        .result_ready(result_ready)
    );

endmodule
